### hdl/gjk_pkg.sv
// ----------------------------------------------------------------------------
// gjk_pkg
// Shared types and codes for the gjk simplex reduction block: operand and
// destination codes of the multiply-accumulate unit and its control tag.
// ----------------------------------------------------------------------------
package gjk_pkg;

   localparam int DIR_BITS = 56;

   // operand codes, vector bases are 4-aligned so a component index is added
   typedef logic [4:0] opnd_type;
   localparam opnd_type OP_U    = 5'd0;
   localparam opnd_type OP_V    = 5'd4;
   localparam opnd_type OP_O    = 5'd8;
   localparam opnd_type OP_N    = 5'd12;
   localparam opnd_type OP_UU   = 5'd16;
   localparam opnd_type OP_UV   = 5'd17;
   localparam opnd_type OP_VV   = 5'd18;
   localparam opnd_type OP_UO   = 5'd19;
   localparam opnd_type OP_VO   = 5'd20;
   localparam opnd_type OP_NONE = 5'd31;

   // destination codes of an accumulation result
   typedef logic [3:0] dest_type;
   localparam dest_type D_NONE = 4'd0;
   localparam dest_type D_N    = 4'd1;
   localparam dest_type D_UU   = 4'd4;
   localparam dest_type D_UV   = 4'd5;
   localparam dest_type D_VV   = 4'd6;
   localparam dest_type D_UO   = 4'd7;
   localparam dest_type D_VO   = 4'd8;
   localparam dest_type D_ND   = 4'd9;
   localparam dest_type D_T1   = 4'd10;
   localparam dest_type D_T2   = 4'd11;
   localparam dest_type D_D    = 4'd12;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     neg;
      dest_type dest;
   } mac_tag_type;

endpackage

### hdl/gjk_simplex_update.sv
// ----------------------------------------------------------------------------
// gjk_simplex_update
// One GJK nearest-simplex reduction step in 3D with exact integer arithmetic,
// built around one shared multiply-accumulate unit under a sequencer.
// ----------------------------------------------------------------------------
// a non-closing point is stored while idle; the closing point starts an evaluation,
// which feeds the shared multiply-accumulate unit one product per cycle in each phase
// results then leave one per cycle while rsp_stall is low;
// no new point is taken until the last is out
// synchronous reset clears the point count and the sequencer; stored points
// and arithmetic registers are not reset
module gjk_simplex_update #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_point_x,
   input  logic signed [COORD_BITS-1:0]           req_point_y,
   input  logic signed [COORD_BITS-1:0]           req_point_z,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_BITS-1:0]           rsp_kept_x,
   output logic signed [COORD_BITS-1:0]           rsp_kept_y,
   output logic signed [COORD_BITS-1:0]           rsp_kept_z,
   output logic signed [gjk_pkg::DIR_BITS-1:0]    rsp_dir_x,
   output logic signed [gjk_pkg::DIR_BITS-1:0]    rsp_dir_y,
   output logic signed [gjk_pkg::DIR_BITS-1:0]    rsp_dir_z,
   output logic                                   rsp_contains_origin,
   output logic                                   rsp_last_kept
);

   localparam int EDGE_W = COORD_BITS + 1;
   localparam int NRM_W  = 2 * COORD_BITS + 3;
   localparam int MUL_W  = 2 * COORD_BITS + 4;
   localparam int ACC_W  = (2 * MUL_W + 2 > gjk_pkg::DIR_BITS) ?
                           2 * MUL_W + 2 : gjk_pkg::DIR_BITS;
   localparam int DW     = gjk_pkg::DIR_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_CROSS, ST_NDOT, ST_DOTS, ST_TESTS, ST_DIRS, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {MD_LINE, MD_TRI, MD_TET} mode_type;

   state_type state_ff;
   mode_type  mode_ff;

   logic signed [COORD_BITS-1:0] pt_ff [4][3];
   logic signed [EDGE_W-1:0]     u_ff [3];
   logic signed [EDGE_W-1:0]     v_ff [3];
   logic signed [NRM_W-1:0]      n_ff [3];
   logic signed [MUL_W-1:0]      suu_ff, suv_ff, svv_ff, suo_ff, svo_ff;
   logic                         nd_ff, t1_ff, t2_ff;
   logic signed [DW-1:0]         dir_ff [3];
   logic [1:0]                   keep_ff [4];
   logic [2:0]                   nkeep_ff;
   logic [1:0]                   k_ff;
   logic                         inside_ff;
   logic [1:0]                   face_ff, fb_ff, fc_ff;
   logic                         usev_ff;
   logic [2:0]                   cnt_ff, evcnt_ff;
   logic [2:0]                   grp_ff, grp_in;
   logic [1:0]                   cmp_ff, cmp_in;

   logic signed [EDGE_W-1:0]     e_w  [3][3];
   logic signed [EDGE_W-1:0]     ao_w [3];
   logic signed [EDGE_W-1:0]     fu_w [3];
   logic signed [EDGE_W-1:0]     fv_w [3];
   logic [1:0]                   ffb_w, ffc_w, ld_face;

   logic [2:0]                   ngrp;
   logic [1:0]                   ncmp_last;
   logic                         done;
   logic [1:0]                   j1, j2;
   gjk_pkg::opnd_type            code_a, code_b;
   gjk_pkg::mac_tag_type         tag_in, tag_out;
   logic signed [MUL_W-1:0]      op_a, op_b;
   logic signed [ACC_W-1:0]      acc;
   logic                         acc_pos;
   logic                         uo_pos, vo_pos, go_ab, line_now;

   // edges from point a and the vector to the origin
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            e_w[i][j] = EDGE_W'(pt_ff[i+1][j]) - EDGE_W'(pt_ff[0][j]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         ao_w[j] = -EDGE_W'(pt_ff[0][j]);
      end
   end

   // tetrahedron face to load
   assign ld_face = (state_ff == ST_NDOT) ? face_ff + 2'd1 : 2'd0;

   always_comb begin
      unique case (ld_face)
         2'd1: begin
            fu_w = e_w[1]; fv_w = e_w[2]; ffb_w = 2'd2; ffc_w = 2'd3;
         end
         2'd2: begin
            fu_w = e_w[2]; fv_w = e_w[0]; ffb_w = 2'd3; ffc_w = 2'd1;
         end
         default: begin
            fu_w = e_w[0]; fv_w = e_w[1]; ffb_w = 2'd1; ffc_w = 2'd2;
         end
      endcase
   end

   // phase shape: groups of accumulations and products per group
   always_comb begin
      unique case (state_ff)
         ST_CROSS: begin ngrp = 3'd3; ncmp_last = 2'd1; end
         ST_NDOT:  begin ngrp = 3'd1; ncmp_last = 2'd2; end
         ST_DOTS:  begin ngrp = 3'd5; ncmp_last = 2'd2; end
         ST_TESTS: begin ngrp = 3'd2; ncmp_last = 2'd1; end
         ST_DIRS:  begin ngrp = 3'd3; ncmp_last = 2'd1; end
         default:  begin ngrp = 3'd0; ncmp_last = 2'd0; end
      endcase
   end

   assign done = (grp_ff == ngrp) && (cmp_ff == 2'd1);

   always_comb begin
      if (grp_ff == ngrp) begin
         grp_in = grp_ff;
         cmp_in = cmp_ff + 2'd1;
      end else if (cmp_ff == ncmp_last) begin
         grp_in = grp_ff + 3'd1;
         cmp_in = 2'd0;
      end else begin
         grp_in = grp_ff;
         cmp_in = cmp_ff + 2'd1;
      end
   end

   // micro-op decode
   assign j1 = (grp_ff[1:0] == 2'd2) ? 2'd0 : grp_ff[1:0] + 2'd1;
   assign j2 = (grp_ff[1:0] == 2'd0) ? 2'd2 : grp_ff[1:0] - 2'd1;

   always_comb begin
      code_a = gjk_pkg::OP_NONE;
      code_b = gjk_pkg::OP_NONE;
      tag_in = '0;
      if (grp_ff != ngrp) begin
         tag_in.valid = 1'b1;
         tag_in.first = (cmp_ff == 2'd0);
         tag_in.dest  = gjk_pkg::D_NONE;
         unique case (state_ff)
            ST_CROSS: begin
               if (cmp_ff == 2'd0) begin
                  code_a = gjk_pkg::OP_U + {3'b000, j1};
                  code_b = gjk_pkg::OP_V + {3'b000, j2};
               end else begin
                  code_a      = gjk_pkg::OP_U + {3'b000, j2};
                  code_b      = gjk_pkg::OP_V + {3'b000, j1};
                  tag_in.neg  = 1'b1;
                  tag_in.dest = gjk_pkg::D_N + {2'b00, grp_ff[1:0]};
               end
            end
            ST_NDOT: begin
               code_a = gjk_pkg::OP_N + {3'b000, cmp_ff};
               code_b = gjk_pkg::OP_O + {3'b000, cmp_ff};
               if (cmp_ff == 2'd2) tag_in.dest = gjk_pkg::D_ND;
            end
            ST_DOTS: begin
               unique case (grp_ff)
                  3'd0: begin
                     code_a = gjk_pkg::OP_U; code_b = gjk_pkg::OP_U;
                     tag_in.dest = gjk_pkg::D_UU;
                  end
                  3'd1: begin
                     code_a = gjk_pkg::OP_U; code_b = gjk_pkg::OP_V;
                     tag_in.dest = gjk_pkg::D_UV;
                  end
                  3'd2: begin
                     code_a = gjk_pkg::OP_V; code_b = gjk_pkg::OP_V;
                     tag_in.dest = gjk_pkg::D_VV;
                  end
                  3'd3: begin
                     code_a = gjk_pkg::OP_U; code_b = gjk_pkg::OP_O;
                     tag_in.dest = gjk_pkg::D_UO;
                  end
                  default: begin
                     code_a = gjk_pkg::OP_V; code_b = gjk_pkg::OP_O;
                     tag_in.dest = gjk_pkg::D_VO;
                  end
               endcase
               code_a = code_a + {3'b000, cmp_ff};
               code_b = code_b + {3'b000, cmp_ff};
               if (cmp_ff != 2'd2) tag_in.dest = gjk_pkg::D_NONE;
            end
            ST_TESTS: begin
               if (grp_ff == 3'd0) begin
                  if (cmp_ff == 2'd0) begin
                     code_a = gjk_pkg::OP_UV; code_b = gjk_pkg::OP_VO;
                  end else begin
                     code_a = gjk_pkg::OP_VV; code_b = gjk_pkg::OP_UO;
                     tag_in.neg = 1'b1; tag_in.dest = gjk_pkg::D_T1;
                  end
               end else begin
                  if (cmp_ff == 2'd0) begin
                     code_a = gjk_pkg::OP_UV; code_b = gjk_pkg::OP_UO;
                  end else begin
                     code_a = gjk_pkg::OP_UU; code_b = gjk_pkg::OP_VO;
                     tag_in.neg = 1'b1; tag_in.dest = gjk_pkg::D_T2;
                  end
               end
            end
            ST_DIRS: begin
               if (cmp_ff == 2'd0) begin
                  code_a = gjk_pkg::OP_O + {3'b000, grp_ff[1:0]};
                  code_b = usev_ff ? gjk_pkg::OP_VV : gjk_pkg::OP_UU;
               end else begin
                  code_a = (usev_ff ? gjk_pkg::OP_V : gjk_pkg::OP_U) +
                           {3'b000, grp_ff[1:0]};
                  code_b = usev_ff ? gjk_pkg::OP_VO : gjk_pkg::OP_UO;
                  tag_in.neg  = 1'b1;
                  tag_in.dest = gjk_pkg::D_D + {2'b00, grp_ff[1:0]};
               end
            end
            default: tag_in = '0;
         endcase
      end
   end

   function automatic logic signed [MUL_W-1:0] opnd(input gjk_pkg::opnd_type code);
      logic signed [MUL_W-1:0] r;
      r = '0;
      unique case (code)
         gjk_pkg::OP_U:         r = MUL_W'(u_ff[0]);
         gjk_pkg::OP_U + 5'd1:  r = MUL_W'(u_ff[1]);
         gjk_pkg::OP_U + 5'd2:  r = MUL_W'(u_ff[2]);
         gjk_pkg::OP_V:         r = MUL_W'(v_ff[0]);
         gjk_pkg::OP_V + 5'd1:  r = MUL_W'(v_ff[1]);
         gjk_pkg::OP_V + 5'd2:  r = MUL_W'(v_ff[2]);
         gjk_pkg::OP_O:         r = MUL_W'(ao_w[0]);
         gjk_pkg::OP_O + 5'd1:  r = MUL_W'(ao_w[1]);
         gjk_pkg::OP_O + 5'd2:  r = MUL_W'(ao_w[2]);
         gjk_pkg::OP_N:         r = MUL_W'(n_ff[0]);
         gjk_pkg::OP_N + 5'd1:  r = MUL_W'(n_ff[1]);
         gjk_pkg::OP_N + 5'd2:  r = MUL_W'(n_ff[2]);
         gjk_pkg::OP_UU:        r = suu_ff;
         gjk_pkg::OP_UV:        r = suv_ff;
         gjk_pkg::OP_VV:        r = svv_ff;
         gjk_pkg::OP_UO:        r = suo_ff;
         gjk_pkg::OP_VO:        r = svo_ff;
         default:               r = '0;
      endcase
      return r;
   endfunction

   assign op_a = opnd(code_a);
   assign op_b = opnd(code_b);

   gjk_mac #(
      .MUL_W (MUL_W),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_in),
      .op_a    (op_a),
      .op_b    (op_b),
      .tag_out (tag_out),
      .acc_out (acc)
   );

   assign acc_pos  = !acc[ACC_W-1] && (acc != '0);
   assign uo_pos   = !suo_ff[MUL_W-1] && (suo_ff != '0);
   assign vo_pos   = !svo_ff[MUL_W-1] && (svo_ff != '0);
   assign go_ab    = (t1_ff && !vo_pos) || (!t1_ff && t2_ff);
   assign line_now = done && (((state_ff == ST_DOTS) && (mode_ff == MD_LINE)) ||
                              ((state_ff == ST_TESTS) && go_ab));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         grp_ff   <= '0;
         cmp_ff   <= '0;
         k_ff     <= '0;
      end else begin
         // accumulation results
         if (tag_out.valid) begin
            unique case (tag_out.dest)
               gjk_pkg::D_N:        n_ff[0] <= acc[NRM_W-1:0];
               gjk_pkg::D_N + 4'd1: n_ff[1] <= acc[NRM_W-1:0];
               gjk_pkg::D_N + 4'd2: n_ff[2] <= acc[NRM_W-1:0];
               gjk_pkg::D_UU:       suu_ff  <= acc[MUL_W-1:0];
               gjk_pkg::D_UV:       suv_ff  <= acc[MUL_W-1:0];
               gjk_pkg::D_VV:       svv_ff  <= acc[MUL_W-1:0];
               gjk_pkg::D_UO:       suo_ff  <= acc[MUL_W-1:0];
               gjk_pkg::D_VO:       svo_ff  <= acc[MUL_W-1:0];
               gjk_pkg::D_ND:       nd_ff   <= acc_pos;
               gjk_pkg::D_T1:       t1_ff   <= acc_pos;
               gjk_pkg::D_T2:       t2_ff   <= acc_pos;
               gjk_pkg::D_D:        dir_ff[0] <= acc[DW-1:0];
               gjk_pkg::D_D + 4'd1: dir_ff[1] <= acc[DW-1:0];
               gjk_pkg::D_D + 4'd2: dir_ff[2] <= acc[DW-1:0];
               default: ;
            endcase
         end

         if ((state_ff == ST_CROSS) || (state_ff == ST_NDOT) || (state_ff == ST_DOTS) ||
             (state_ff == ST_TESTS) || (state_ff == ST_DIRS)) begin
            if (done) begin
               grp_ff <= '0;
               cmp_ff <= '0;
            end else begin
               grp_ff <= grp_in;
               cmp_ff <= cmp_in;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (cnt_ff < 3'd4) begin
                     pt_ff[cnt_ff[1:0]][0] <= req_point_x;
                     pt_ff[cnt_ff[1:0]][1] <= req_point_y;
                     pt_ff[cnt_ff[1:0]][2] <= req_point_z;
                  end
                  if (req_last_point) begin
                     evcnt_ff <= (cnt_ff < 3'd4) ? cnt_ff + 3'd1 : 3'd4;
                     cnt_ff   <= '0;
                     state_ff <= ST_SETUP;
                  end else if (cnt_ff < 3'd4) begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            ST_SETUP: begin
               inside_ff <= 1'b0;
               k_ff      <= '0;
               unique case (evcnt_ff)
                  3'd1: begin
                     keep_ff[0] <= 2'd0;
                     nkeep_ff   <= 3'd1;
                     dir_ff     <= '{default: '0};
                     state_ff   <= ST_EMIT;
                  end
                  3'd2: begin
                     u_ff     <= e_w[0];
                     v_ff     <= e_w[0];
                     fb_ff    <= 2'd1;
                     mode_ff  <= MD_LINE;
                     state_ff <= ST_DOTS;
                  end
                  3'd3: begin
                     u_ff     <= fu_w;
                     v_ff     <= fv_w;
                     fb_ff    <= ffb_w;
                     fc_ff    <= ffc_w;
                     mode_ff  <= MD_TRI;
                     state_ff <= ST_CROSS;
                  end
                  default: begin
                     u_ff     <= fu_w;
                     v_ff     <= fv_w;
                     fb_ff    <= ffb_w;
                     fc_ff    <= ffc_w;
                     face_ff  <= 2'd0;
                     mode_ff  <= MD_TET;
                     state_ff <= ST_CROSS;
                  end
               endcase
            end
            ST_CROSS: begin
               if (done) state_ff <= ST_NDOT;
            end
            ST_NDOT: begin
               if (done) begin
                  if (mode_ff != MD_TET) begin
                     state_ff <= ST_DOTS;
                  end else if (nd_ff) begin
                     mode_ff  <= MD_TRI;
                     state_ff <= ST_DOTS;
                  end else if (face_ff == 2'd2) begin
                     // origin enclosed
                     inside_ff  <= 1'b1;
                     keep_ff[0] <= 2'd0;
                     keep_ff[1] <= 2'd1;
                     keep_ff[2] <= 2'd2;
                     keep_ff[3] <= 2'd3;
                     nkeep_ff   <= 3'd4;
                     dir_ff     <= '{default: '0};
                     state_ff   <= ST_EMIT;
                  end else begin
                     face_ff  <= ld_face;
                     u_ff     <= fu_w;
                     v_ff     <= fv_w;
                     fb_ff    <= ffb_w;
                     fc_ff    <= ffc_w;
                     state_ff <= ST_CROSS;
                  end
               end
            end
            ST_DOTS, ST_TESTS: begin
               if (line_now) begin
                  keep_ff[0] <= 2'd0;
                  if (uo_pos) begin
                     keep_ff[1] <= fb_ff;
                     nkeep_ff   <= 3'd2;
                     usev_ff    <= 1'b0;
                     state_ff   <= ST_DIRS;
                  end else begin
                     nkeep_ff <= 3'd1;
                     for (int j = 0; j < 3; j++) begin
                        dir_ff[j] <= DW'(ao_w[j]);
                     end
                     state_ff <= ST_EMIT;
                  end
               end else if (done) begin
                  if (state_ff == ST_DOTS) begin
                     state_ff <= ST_TESTS;
                  end else if (t1_ff) begin
                     keep_ff[0] <= 2'd0;
                     keep_ff[1] <= fc_ff;
                     nkeep_ff   <= 3'd2;
                     usev_ff    <= 1'b1;
                     state_ff   <= ST_DIRS;
                  end else begin
                     nkeep_ff <= 3'd3;
                     keep_ff[1] <= fb_ff;
                     if (nd_ff) begin
                        keep_ff[0] <= 2'd0;
                        keep_ff[2] <= fc_ff;
                        for (int j = 0; j < 3; j++) begin
                           dir_ff[j] <= DW'(n_ff[j]);
                        end
                     end else begin
                        keep_ff[0] <= fc_ff;
                        keep_ff[2] <= 2'd0;
                        for (int j = 0; j < 3; j++) begin
                           dir_ff[j] <= DW'(-(ACC_W'(n_ff[j])));
                        end
                     end
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_DIRS: begin
               if (done) state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  if (rsp_last_kept) begin
                     k_ff     <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_EMIT);
   assign rsp_kept_x          = pt_ff[keep_ff[k_ff]][0];
   assign rsp_kept_y          = pt_ff[keep_ff[k_ff]][1];
   assign rsp_kept_z          = pt_ff[keep_ff[k_ff]][2];
   assign rsp_dir_x           = dir_ff[0];
   assign rsp_dir_y           = dir_ff[1];
   assign rsp_dir_z           = dir_ff[2];
   assign rsp_contains_origin = inside_ff;
   assign rsp_last_kept       = (({1'b0, k_ff} + 3'd1) == nkeep_ff);

endmodule

### hdl/gjk_mac.sv
// ----------------------------------------------------------------------------
// gjk_mac
// Shared signed multiply-accumulate unit: registered product, then an
// accumulator that clears, adds or subtracts under a tag carried alongside.
// ----------------------------------------------------------------------------
module gjk_mac #(
   parameter int MUL_W = 36,
   parameter int ACC_W = 74
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gjk_pkg::mac_tag_type     tag_in,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output gjk_pkg::mac_tag_type     tag_out,
   output logic signed [ACC_W-1:0] acc_out
);

   gjk_pkg::mac_tag_type      tag_ff;
   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   acc_base;
   logic signed [ACC_W-1:0]   acc_in;

   assign prod_ext = ACC_W'(prod_ff);
   assign acc_base = tag_ff.first ? {ACC_W{1'b0}} : acc_ff;
   assign acc_in   = tag_ff.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff  <= tag_in;
         prod_ff <= op_a * op_b;
         if (tag_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign tag_out = tag_ff;
   assign acc_out = acc_in;

endmodule

### hdl/gjk_check.sv
// ----------------------------------------------------------------------------
// gjk_check
// Port-level checks for gjk_simplex_update, attached by bind.
// ----------------------------------------------------------------------------
module gjk_check #(
   parameter int COORD_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_last_point,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [COORD_BITS-1:0]        rsp_kept_x,
   input logic signed [gjk_pkg::DIR_BITS-1:0] rsp_dir_x,
   input logic signed [gjk_pkg::DIR_BITS-1:0] rsp_dir_y,
   input logic signed [gjk_pkg::DIR_BITS-1:0] rsp_dir_z,
   input logic                                rsp_contains_origin,
   input logic                                rsp_last_kept
);

   // no new transaction while results are pending
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_point) |=> req_stall)
      else $error("closing point did not start evaluation");

   a_open_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_last_point) |=> !rsp_valid)
      else $error("result without closing point");

   a_inside_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contains_origin) |->
         (rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0))
      else $error("nonzero direction with origin enclosed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kept_x) && $stable(rsp_dir_x) && $stable(rsp_last_kept)))
      else $error("stalled result changed");

endmodule

bind gjk_simplex_update gjk_check #(.COORD_BITS(COORD_BITS)) u_gjk_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_last_point      (req_last_point),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kept_x          (rsp_kept_x),
   .rsp_dir_x           (rsp_dir_x),
   .rsp_dir_y           (rsp_dir_y),
   .rsp_dir_z           (rsp_dir_z),
   .rsp_contains_origin (rsp_contains_origin),
   .rsp_last_kept       (rsp_last_kept)
);
